/* hdl/assert_macros.svh */
// Assertion macros for the file that checks design properties.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define BFP_ASSERT_NEVER(label, cond, msg) \
   `BFP_ASSERT(label, !(cond), msg)

`endif

/* hdl/bfp_pkg.sv */
// Package with the types and constants of the balance frame parser.
`timescale 1ns / 1ps

package bfp_pkg;

   // Frame layout
   localparam int FRAME_LENGTH  = 22;
   localparam int SIGN_POSITION = 6;
   localparam int FIELD_OFFSET  = 7;
   localparam int FIELD_LENGTH  = 10;
   localparam int POS_W         = 5;

   // Tick counter and register widths
   localparam int TICK_W = 10;
   localparam logic [TICK_W-1:0] TICK_LIMIT = TICK_W'(999);
   localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(3);
   localparam logic [7:0] START_RESET = 8'h4E;

   // Reading widths and limits
   localparam int MAG_W  = 30;
   localparam int FRAC_W = 4;
   localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(999999999);
   localparam logic [MAG_W-1:0] MAG_GUARD = MAG_W'(100000000);
   localparam logic [FRAC_W-1:0] FRAC_SAT = FRAC_W'(15);
   localparam logic [FRAC_W-1:0] FRACTION_MAX = FRAC_W'(FIELD_LENGTH - 1);

   // Character codes
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Input action codes
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_TIMEOUT = 1'b0;
   localparam logic REG_START   = 1'b1;

   // Queue between front and back
   localparam int QUEUE_DEPTH   = 4;
   localparam int QUEUE_ADDR_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified word
   typedef struct packed {
      logic       is_tick;
      logic       is_start;
      logic       is_blank;
      logic       is_plus;
      logic       is_minus;
      logic       is_point;
      logic       is_digit;
      logic [3:0] digit;
   } item_class_type;

   // Queue status seen by front, back and checks
   typedef struct packed {
      logic [QUEUE_COUNT_W-1:0] count;
      logic                     full;
      logic                     head_valid;
   } queue_status_type;

endpackage

/* hdl/bfp_req_if.sv */
// Input channel: one received byte or tick per word.
`timescale 1ns / 1ps

interface bfp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

/* hdl/bfp_rsp_if.sv */
// Result channel: one reading word per input word.
`timescale 1ns / 1ps

interface bfp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        reading_ready;
   logic [bfp_pkg::MAG_W-1:0]   reading_magnitude;
   logic [bfp_pkg::FRAC_W-1:0]  reading_fraction_digits;
   logic                        reading_negative;
   logic                        online;

   modport source (output valid, output reading_ready, output reading_magnitude,
                   output reading_fraction_digits, output reading_negative,
                   output online, input ready);
   modport sink (input valid, input reading_ready, input reading_magnitude,
                 input reading_fraction_digits, input reading_negative,
                 input online, output ready);
endinterface

/* hdl/bfp_front.sv */
// Front end: accepts input words and classifies each byte.
`timescale 1ns / 1ps

module bfp_front (
   bfp_req_if.sink                   req,
   input  logic [7:0]                start_byte,
   input  bfp_pkg::queue_status_type q_status,
   output logic                      push,
   output bfp_pkg::item_class_type   push_item
);

   logic [7:0] c;

   assign c         = req.rx_byte;
   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   // Character classes
   always_comb begin
      push_item          = '0;
      push_item.is_tick  = (req.action == bfp_pkg::ACTION_TICK);
      push_item.is_start = (c == start_byte);
      push_item.is_blank = (c == bfp_pkg::CHAR_SPACE) ||
                           (c inside {[bfp_pkg::CHAR_TAB:bfp_pkg::CHAR_CR]});
      push_item.is_plus  = (c == bfp_pkg::CHAR_PLUS);
      push_item.is_minus = (c == bfp_pkg::CHAR_MINUS);
      push_item.is_point = (c == bfp_pkg::CHAR_POINT);
      push_item.is_digit = c inside {[bfp_pkg::CHAR_ZERO:bfp_pkg::CHAR_NINE]};
      // low nibble of an ASCII digit is its value
      push_item.digit    = c[3:0];
   end

endmodule

/* hdl/bfp_queue.sv */
// Short queue of classified words between front and back.
`timescale 1ns / 1ps

module bfp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfp_pkg::item_class_type   push_item,
   input  logic                      pop,
   output bfp_pkg::item_class_type   head_item,
   output bfp_pkg::queue_status_type status
);

   bfp_pkg::item_class_type slots_ff [bfp_pkg::QUEUE_DEPTH];

   logic [bfp_pkg::QUEUE_ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bfp_pkg::QUEUE_ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bfp_pkg::QUEUE_COUNT_W-1:0] count_ff, count_in;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item         = slots_ff[rd_ptr_ff];
   assign status.count      = count_ff;
   assign status.full       = (count_ff == bfp_pkg::QUEUE_COUNT_W'(bfp_pkg::QUEUE_DEPTH));
   assign status.head_valid = (count_ff != '0);

endmodule

/* hdl/bfp_back.sv */
// Back end: frame tracking, number parsing, held reading and online timer.
`timescale 1ns / 1ps

module bfp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [bfp_pkg::TICK_W-1:0]    timeout_ticks,
   input  bfp_pkg::item_class_type       head_item,
   input  bfp_pkg::queue_status_type     q_status,
   output logic                          pop,
   bfp_rsp_if.source                     rsp
);

   typedef enum logic [1:0] {
      PH_LEAD    = 2'd0,
      PH_SIGNED  = 2'd1,
      PH_DIGITS  = 2'd2,
      PH_STOPPED = 2'd3
   } phase_type;

   localparam logic [bfp_pkg::POS_W:0] FIELD_START = (bfp_pkg::POS_W+1)'(bfp_pkg::FIELD_OFFSET);
   localparam logic [bfp_pkg::POS_W:0] FIELD_END =
      (bfp_pkg::POS_W+1)'(bfp_pkg::FIELD_OFFSET + bfp_pkg::FIELD_LENGTH);
   localparam logic [bfp_pkg::POS_W:0] FRAME_END = (bfp_pkg::POS_W+1)'(bfp_pkg::FRAME_LENGTH);
   localparam logic [bfp_pkg::POS_W-1:0] SIGN_POS = bfp_pkg::POS_W'(bfp_pkg::SIGN_POSITION);

   phase_type                    phase_ff, phase_in;
   logic [bfp_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [bfp_pkg::MAG_W-1:0]    acc_ff, acc_in;
   logic [bfp_pkg::FRAC_W-1:0]   frac_ff, frac_in;
   logic                         point_ff, point_in;
   logic                         fsign_ff, fsign_in;
   logic                         frame_neg_ff, frame_neg_in;
   logic [bfp_pkg::MAG_W-1:0]    held_mag_ff, held_mag_in;
   logic [bfp_pkg::FRAC_W-1:0]   held_frac_ff, held_frac_in;
   logic                         held_neg_ff, held_neg_in;
   logic                         online_ff, online_in;
   logic [bfp_pkg::TICK_W-1:0]   ticks_ff, ticks_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rdy_flag_ff, rdy_flag_in;

   logic [bfp_pkg::POS_W:0]      pos_ext;
   logic [bfp_pkg::POS_W:0]      pos_next;
   logic                         take;

   assign pop      = q_status.head_valid && (!rsp_valid_ff || rsp.ready);
   assign pos_ext  = {1'b0, pos_ff};
   assign pos_next = pos_ext + 1'b1;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      acc_in       = acc_ff;
      frac_in      = frac_ff;
      point_in     = point_ff;
      fsign_in     = fsign_ff;
      frame_neg_in = frame_neg_ff;
      held_mag_in  = held_mag_ff;
      held_frac_in = held_frac_ff;
      held_neg_in  = held_neg_ff;
      online_in    = online_ff;
      ticks_in     = ticks_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rdy_flag_in  = rdy_flag_ff;
      take         = 1'b0;

      if (pop) begin
         rsp_valid_in = 1'b1;
         rdy_flag_in  = 1'b0;
         if (head_item.is_tick) begin
            // saturating tick count, online drops on equality
            if (ticks_ff < bfp_pkg::TICK_LIMIT) begin
               ticks_in = ticks_ff + 1'b1;
            end
            if (ticks_in == timeout_ticks) begin
               online_in = 1'b0;
            end
         end else if (pos_ff == '0) begin
            // waiting for the start byte
            if (head_item.is_start) begin
               acc_in       = '0;
               frac_in      = '0;
               point_in     = 1'b0;
               phase_in     = PH_LEAD;
               fsign_in     = 1'b0;
               frame_neg_in = 1'b0;
               pos_in       = bfp_pkg::POS_W'(1);
            end
         end else begin
            if (pos_ff == SIGN_POS) begin
               frame_neg_in = head_item.is_minus;
            end

            // number field
            if (pos_ext >= FIELD_START && pos_ext < FIELD_END) begin
               case (phase_ff)
                  PH_LEAD: begin
                     if (head_item.is_blank) begin
                        phase_in = PH_LEAD;
                     end else if (head_item.is_plus || head_item.is_minus) begin
                        fsign_in = head_item.is_minus;
                        phase_in = PH_SIGNED;
                     end else if (head_item.is_digit) begin
                        phase_in = PH_DIGITS;
                        take     = 1'b1;
                     end else if (head_item.is_point) begin
                        point_in = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_STOPPED;
                     end
                  end
                  PH_SIGNED, PH_DIGITS: begin
                     if (head_item.is_digit) begin
                        phase_in = PH_DIGITS;
                        take     = 1'b1;
                     end else if (head_item.is_point && !point_ff) begin
                        point_in = 1'b1;
                        phase_in = PH_DIGITS;
                     end else begin
                        phase_in = PH_STOPPED;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase

               // digit accumulate with overflow guard
               if (take) begin
                  if (acc_ff >= bfp_pkg::MAG_GUARD) begin
                     if (!point_ff) begin
                        acc_in   = bfp_pkg::MAG_MAX;
                        frac_in  = '0;
                        phase_in = PH_STOPPED;
                     end
                  end else begin
                     acc_in = (acc_ff << 3) + (acc_ff << 1) +
                              {{(bfp_pkg::MAG_W-4){1'b0}}, head_item.digit};
                     if (point_ff && frac_ff < bfp_pkg::FRAC_SAT) begin
                        frac_in = frac_ff + 1'b1;
                     end
                  end
               end
            end

            // frame end: latch the reading
            if (pos_next >= FRAME_END) begin
               pos_in       = '0;
               held_mag_in  = acc_in;
               held_frac_in = frac_in;
               held_neg_in  = fsign_in ^ frame_neg_in;
               ticks_in     = '0;
               online_in    = 1'b1;
               rdy_flag_in  = 1'b1;
            end else begin
               pos_in = pos_next[bfp_pkg::POS_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_LEAD;
         pos_ff       <= '0;
         acc_ff       <= '0;
         frac_ff      <= '0;
         point_ff     <= 1'b0;
         fsign_ff     <= 1'b0;
         frame_neg_ff <= 1'b0;
         held_mag_ff  <= '0;
         held_frac_ff <= '0;
         held_neg_ff  <= 1'b0;
         online_ff    <= 1'b0;
         ticks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rdy_flag_ff  <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         acc_ff       <= acc_in;
         frac_ff      <= frac_in;
         point_ff     <= point_in;
         fsign_ff     <= fsign_in;
         frame_neg_ff <= frame_neg_in;
         held_mag_ff  <= held_mag_in;
         held_frac_ff <= held_frac_in;
         held_neg_ff  <= held_neg_in;
         online_ff    <= online_in;
         ticks_ff     <= ticks_in;
         rsp_valid_ff <= rsp_valid_in;
         rdy_flag_ff  <= rdy_flag_in;
      end
   end

   // held state only changes on a pop, so it stands as the result word
   assign rsp.valid                   = rsp_valid_ff;
   assign rsp.reading_ready           = rdy_flag_ff;
   assign rsp.reading_magnitude       = held_mag_ff;
   assign rsp.reading_fraction_digits = held_frac_ff;
   assign rsp.reading_negative        = held_neg_ff;
   assign rsp.online                  = online_ff;

endmodule

/* hdl/balance_frame_parser_unit.sv */
// Balance frame parser: front classifier, word queue, back parser, CSR port.
// Each accepted input word is written into the queue, and a pop then loads the registered result word.
// Throughput: one word per cycle while the result receiver does not stall.
// A 4-deep queue lets input words keep arriving while a result waits.
// Reset is synchronous, active high: clears queue, parser, reading, timer; loads CSR defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module balance_frame_parser_unit (
   input  logic                            clock,
   input  logic                            reset,
   bfp_req_if.sink                         req,
   bfp_rsp_if.source                       rsp,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [bfp_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   logic [bfp_pkg::TICK_W-1:0] timeout_ff, timeout_in;
   logic [7:0]                 start_ff, start_in;
   logic                       csr_write;

   bfp_pkg::queue_status_type  q_status;
   bfp_pkg::item_class_type    push_item;
   bfp_pkg::item_class_type    head_item;
   logic                       push;
   logic                       pop;

   // Configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      timeout_in = timeout_ff;
      start_in   = start_ff;
      if (csr_write) begin
         if (csr_paddr[2] == bfp_pkg::REG_START) begin
            start_in = csr_pwdata[7:0];
         end else begin
            timeout_in = csr_pwdata[bfp_pkg::TICK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= bfp_pkg::TIMEOUT_RESET;
         start_ff   <= bfp_pkg::START_RESET;
      end else begin
         timeout_ff <= timeout_in;
         start_ff   <= start_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == bfp_pkg::REG_TIMEOUT) ?
                       {{(32-bfp_pkg::TICK_W){1'b0}}, timeout_ff} :
                       {24'd0, start_ff};

   bfp_front u_front (
      .req       (req),
      .start_byte(start_ff),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   bfp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_item(push_item),
      .pop      (pop),
      .head_item(head_item),
      .status   (q_status)
   );

   bfp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .timeout_ticks(timeout_ff),
      .head_item    (head_item),
      .q_status     (q_status),
      .pop          (pop),
      .rsp          (rsp)
   );

   // Checks
   `BFP_ASSERT_NEVER(a_queue_bound, q_status.count > bfp_pkg::QUEUE_COUNT_W'(bfp_pkg::QUEUE_DEPTH), "queue overfilled")
   `BFP_ASSERT(a_frame_online, (rsp.valid && rsp.reading_ready) |-> rsp.online, "frame done but offline")
   `BFP_ASSERT(a_frac_bound, rsp.valid |-> (rsp.reading_fraction_digits <= bfp_pkg::FRACTION_MAX), "fraction count too large")
   `BFP_ASSERT(a_mag_bound, rsp.valid |-> (rsp.reading_magnitude <= bfp_pkg::MAG_MAX), "magnitude above limit")

endmodule

/* tb/balance_frame_parser_unit_test.sv */
// Testbench for the balance frame parser: random frames and ticks, checked word by word.
`timescale 1ns / 1ps

module balance_frame_parser_unit_test;
   import bfp_pkg::*;

   // One input word waiting to be sent, with its lead-in gap
   typedef struct {
      logic        action;
      logic [7:0]  rx_byte;
      int unsigned gap;
      bit          drain;
   } serial_word_type;

   // One result word as the block should report it
   typedef struct packed {
      logic              complete;
      logic [MAG_W-1:0]  magnitude;
      logic [FRAC_W-1:0] fraction;
      logic              negative;
      logic              online;
   } reading_word_type;

   // Parse progress through the number field
   typedef enum logic [1:0] {
      SCAN_BLANKS,
      SCAN_SIGNED,
      SCAN_DIGITS,
      SCAN_STOPPED
   } scan_phase_type;

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bfp_req_if req_ch ();
   bfp_rsp_if rsp_ch ();

   balance_frame_parser_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Stimulus and expectation stores
   serial_word_type  serial_queue[$];
   reading_word_type reading_queue[$];
   logic [7:0]       field_text[$];
   serial_word_type  staged_word;
   bit               word_staged = 1'b0;
   int unsigned      words_queued = 0;
   int unsigned      mismatch_count = 0;
   int unsigned      sender_max_gap = 11;
   int unsigned      receiver_max_stall = 11;
   int unsigned      stall_left = 0;
   reading_word_type want;

   // Predictor registers and state, reset values
   logic [TICK_W-1:0] cfg_timeout = TIMEOUT_RESET;
   logic [7:0]        cfg_start = START_RESET;
   logic [POS_W-1:0]  scan_pos = '0;
   logic [MAG_W-1:0]  scan_value = '0;
   logic [FRAC_W-1:0] scan_fraction = '0;
   logic              scan_point = 1'b0;
   scan_phase_type    scan_phase = SCAN_BLANKS;
   logic              scan_field_neg = 1'b0;
   logic              scan_frame_neg = 1'b0;
   logic [MAG_W-1:0]  held_value = '0;
   logic [FRAC_W-1:0] held_fraction = '0;
   logic              held_neg = 1'b0;
   logic              online_now = 1'b0;
   logic [TICK_W-1:0] tick_count = '0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Digit accumulation with integer overflow clamp
   task automatic take_digit(input logic [3:0] d);
      if (scan_value >= MAG_GUARD) begin
         // past nine digits: clamp in the integer part, drop in the fraction
         if (!scan_point) begin
            scan_value = MAG_MAX;
            scan_fraction = '0;
            scan_phase = SCAN_STOPPED;
         end
      end else begin
         scan_value = MAG_W'(scan_value * 10 + d);
         if (scan_point && scan_fraction != FRAC_SAT)
            scan_fraction = scan_fraction + 1'b1;
      end
   endtask

   // One character of the number field, atof style
   task automatic scan_char(input logic [7:0] c);
      logic is_digit;
      logic is_blank;
      is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      is_blank = (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
      case (scan_phase)
         SCAN_BLANKS: begin
            if (is_blank) begin
               // leading blanks are skipped
            end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               scan_field_neg = (c == CHAR_MINUS);
               scan_phase = SCAN_SIGNED;
            end else if (is_digit) begin
               scan_phase = SCAN_DIGITS;
               take_digit(c[3:0]);
            end else if (c == CHAR_POINT) begin
               scan_point = 1'b1;
               scan_phase = SCAN_DIGITS;
            end else begin
               scan_phase = SCAN_STOPPED;
            end
         end
         SCAN_SIGNED, SCAN_DIGITS: begin
            if (is_digit) begin
               scan_phase = SCAN_DIGITS;
               take_digit(c[3:0]);
            end else if (c == CHAR_POINT && !scan_point) begin
               scan_point = 1'b1;
               scan_phase = SCAN_DIGITS;
            end else begin
               scan_phase = SCAN_STOPPED;
            end
         end
         default: begin
         end
      endcase
   endtask

   // Advance the predicted state by one accepted word and store its reading
   task automatic predict_reading(input logic action, input logic [7:0] c);
      reading_word_type w;
      w.complete = 1'b0;
      if (action == ACTION_TICK) begin
         if (tick_count < TICK_LIMIT)
            tick_count = tick_count + 1'b1;
         if (tick_count == cfg_timeout)
            online_now = 1'b0;
      end else if (scan_pos == 0) begin
         if (c == cfg_start) begin
            scan_value = '0;
            scan_fraction = '0;
            scan_point = 1'b0;
            scan_phase = SCAN_BLANKS;
            scan_field_neg = 1'b0;
            scan_frame_neg = 1'b0;
            scan_pos = 1;
         end
      end else begin
         if (scan_pos == SIGN_POSITION)
            scan_frame_neg = (c == CHAR_MINUS);
         if (scan_pos >= FIELD_OFFSET && scan_pos < FIELD_OFFSET + FIELD_LENGTH)
            scan_char(c);
         scan_pos = scan_pos + 1'b1;
         // last byte of the frame latches the reading
         if (scan_pos >= FRAME_LENGTH) begin
            scan_pos = '0;
            held_value = scan_value;
            held_fraction = scan_fraction;
            held_neg = scan_field_neg ^ scan_frame_neg;
            tick_count = '0;
            online_now = 1'b1;
            w.complete = 1'b1;
         end
      end
      w.magnitude = held_value;
      w.fraction = held_fraction;
      w.negative = held_neg;
      w.online = online_now;
      reading_queue.insert(reading_queue.size(), w);
   endtask

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
         mismatch_count++;
      end
   endfunction

   // Input driver: gap before each word, optional wait for all results
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_reading(req_ch.action, req_ch.rx_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (!word_staged && serial_queue.size() != 0) begin
               staged_word = serial_queue.pop_front();
               word_staged = 1'b1;
            end
            if (word_staged && staged_word.gap == 0 &&
                !(staged_word.drain && reading_queue.size() != 0)) begin
               req_ch.valid <= 1'b1;
               req_ch.action <= staged_word.action;
               req_ch.rx_byte <= staged_word.rx_byte;
               word_staged = 1'b0;
            end else begin
               req_ch.valid <= 1'b0;
               if (word_staged && staged_word.gap != 0)
                  staged_word.gap--;
            end
         end
      end
   end

   // Result monitor: random stall before each word, compare with oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (reading_queue.size() == 0) begin
               $display("%0t: result word with none expected", $time);
               mismatch_count++;
            end else begin
               want = reading_queue.pop_front();
               check_field("reading_ready", want.complete, rsp_ch.reading_ready);
               check_field("reading_magnitude", want.magnitude, rsp_ch.reading_magnitude);
               check_field("reading_fraction_digits", want.fraction,
                           rsp_ch.reading_fraction_digits);
               check_field("reading_negative", want.negative, rsp_ch.reading_negative);
               check_field("online", want.online, rsp_ch.online);
            end
            stall_left = $urandom_range(0, receiver_max_stall);
         end
         if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic queue_word(input logic action, input logic [7:0] c, input bit drain);
      serial_word_type w;
      w.action = action;
      w.rx_byte = c;
      w.gap = $urandom_range(0, sender_max_gap);
      w.drain = drain;
      serial_queue.insert(serial_queue.size(), w);
      words_queued++;
   endtask

   // Append one character to the field text
   task automatic add_text(input logic [7:0] ch);
      field_text.insert(field_text.size(), ch);
   endtask

   function automatic logic [7:0] pick_blank();
      int unsigned r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CHAR_SPACE : CHAR_TAB + 8'(r);
   endfunction

   function automatic logic [7:0] pick_digit();
      return CHAR_ZERO + 8'($urandom_range(0, 9));
   endfunction

   // Fill field_text with one number field of a random style
   task automatic make_field();
      int unsigned r;
      field_text.delete();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: begin
            // well formed: blanks, sign, digits, point, digits
            repeat ($urandom_range(0, 2)) add_text(pick_blank());
            r = $urandom_range(0, 2);
            if (r == 1) add_text(CHAR_PLUS);
            if (r == 2) add_text(CHAR_MINUS);
            repeat ($urandom_range(0, 5)) add_text(pick_digit());
            if ($urandom_range(0, 1) != 0) begin
               add_text(CHAR_POINT);
               repeat ($urandom_range(0, 5)) add_text(pick_digit());
            end
         end
         5: begin
            // ten integer digits overflow the magnitude
            add_text(CHAR_ZERO + 8'($urandom_range(1, 9)));
            repeat (9) add_text(pick_digit());
         end
         6: begin
            repeat (FIELD_LENGTH) add_text(8'($urandom_range(0, 255)));
         end
         7: begin
            // number characters in any order: second sign, second point
            repeat (FIELD_LENGTH) begin
               case ($urandom_range(0, 3))
                  0: add_text(pick_digit());
                  1: add_text(CHAR_POINT);
                  2: add_text($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
                  default: add_text(pick_blank());
               endcase
            end
         end
         8: begin
            // no digits at all
            repeat ($urandom_range(0, 9)) add_text(pick_blank());
            if ($urandom_range(0, 1) != 0) add_text(CHAR_MINUS);
         end
         default: begin
            // nine digits: largest value or longest fraction
            r = $urandom_range(0, 2);
            if (r == 1) add_text(CHAR_POINT);
            repeat (9) add_text((r == 0) ? CHAR_NINE : pick_digit());
            if (r == 2) add_text(CHAR_POINT);
         end
      endcase
      while (field_text.size() < FIELD_LENGTH)
         add_text($urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(0, 255)));
      while (field_text.size() > FIELD_LENGTH)
         void'(field_text.pop_back());
   endtask

   // Queue the first len bytes of a frame around field_text, ticks mixed in
   task automatic queue_frame(input logic [7:0] sign_ch, input int unsigned len);
      logic [7:0] c;
      for (int p = 0; p < len; p++) begin
         if ($urandom_range(0, 15) == 0)
            queue_word(ACTION_TICK, 8'($urandom_range(0, 255)), 1'b0);
         if (p == 0)
            c = cfg_start;
         else if (p == SIGN_POSITION)
            c = sign_ch;
         else if (p >= FIELD_OFFSET && p < FIELD_OFFSET + FIELD_LENGTH)
            c = field_text[p - FIELD_OFFSET];
         else if ($urandom_range(0, 7) == 0)
            c = cfg_start;
         else
            c = 8'($urandom_range(0, 255));
         queue_word(ACTION_BYTE, c, 1'b0);
      end
   endtask

   // Mostly whole frames, some cut short, with noise and ticks between them
   task automatic queue_random_traffic(input int unsigned count);
      int unsigned first;
      logic [7:0]  sign_ch;
      int unsigned len;
      first = words_queued;
      while (words_queued - first < count) begin
         repeat ($urandom_range(0, 2))
            queue_word(ACTION_BYTE, 8'($urandom_range(0, 255)), $urandom_range(0, 63) == 0);
         repeat ($urandom_range(0, 2))
            queue_word(ACTION_TICK, 8'($urandom_range(0, 255)), 1'b0);
         make_field();
         case ($urandom_range(0, 3))
            0: sign_ch = CHAR_MINUS;
            1: sign_ch = CHAR_PLUS;
            2: sign_ch = CHAR_SPACE;
            default: sign_ch = 8'($urandom_range(0, 255));
         endcase
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, FRAME_LENGTH - 1) : FRAME_LENGTH;
         queue_frame(sign_ch, len);
      end
   endtask

   task automatic wait_drained();
      while (serial_queue.size() != 0 || word_staged || req_ch.valid ||
             reading_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_read_check(input logic idx);
      logic [31:0] exp_v;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      exp_v = (idx == REG_TIMEOUT) ? 32'(cfg_timeout) : 32'(cfg_start);
      check_field("csr read", exp_v, csr_prdata);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Register write, then read back
   task automatic csr_write(input logic idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (idx == REG_TIMEOUT)
         cfg_timeout = data[TICK_W-1:0];
      else
         cfg_start = data[7:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_read_check(idx);
   endtask

   // Stimulus sequence
   initial begin
      string lead;
      reset = 1'b1;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      req_ch.valid = 1'b0;
      req_ch.action = ACTION_BYTE;
      req_ch.rx_byte = '0;
      rsp_ch.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      csr_read_check(REG_TIMEOUT);
      csr_read_check(REG_START);

      // Directed: noise, one frame with blanks and a signed fraction, ticks to timeout
      queue_word(ACTION_BYTE, 8'h78, 1'b0);
      lead = "-12.345";
      field_text.delete();
      add_text(CHAR_TAB);
      add_text(CHAR_SPACE);
      for (int i = 0; i < lead.len(); i++) add_text(lead[i]);
      add_text(CHAR_CR);
      queue_frame(CHAR_PLUS, FRAME_LENGTH);
      repeat (3) queue_word(ACTION_TICK, 8'hFF, 1'b0);
      queue_random_traffic(80);
      wait_drained();

      // Shortest timeout, start byte zero
      csr_write(REG_TIMEOUT, 32'd1);
      csr_write(REG_START, 32'h00);
      queue_random_traffic(80);
      wait_drained();

      // Tick counter: timeout lowered below the count
      csr_write(REG_TIMEOUT, 32'd999);
      csr_write(REG_START, 32'hFF);
      make_field();
      queue_frame(CHAR_MINUS, FRAME_LENGTH);
      queue_word(ACTION_TICK, 8'h00, 1'b1);
      repeat (9) queue_word(ACTION_TICK, 8'($urandom_range(0, 255)), 1'b0);
      wait_drained();
      csr_write(REG_TIMEOUT, 32'd5);
      sender_max_gap = 0;
      receiver_max_stall = 0;
      repeat (20) queue_word(ACTION_TICK, 8'($urandom_range(0, 255)), 1'b0);
      wait_drained();

      // Timeout above the tick limit never drops online
      csr_write(REG_TIMEOUT, 32'd1023);
      make_field();
      queue_frame(CHAR_SPACE, FRAME_LENGTH);
      repeat (20) queue_word(ACTION_TICK, 8'($urandom_range(0, 255)), 1'b0);
      wait_drained();

      // Timeout zero never drops online; back-to-back words both ways
      csr_write(REG_TIMEOUT, 32'd0);
      csr_write(REG_START, 32'($urandom_range(0, 255)));
      queue_random_traffic(60);
      wait_drained();
      sender_max_gap = 11;
      receiver_max_stall = 11;

      // Mid timeout, default start byte
      csr_write(REG_TIMEOUT, 32'($urandom_range(2, 20)));
      csr_write(REG_START, 32'(START_RESET));
      queue_random_traffic(80);
      wait_drained();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && reading_queue.size() == 0)
         $display("PASS balance_frame_parser_unit");
      else
         $display("FAIL balance_frame_parser_unit");
      $finish;
   end

   // Run limit, far above the slowest correct run
   initial begin
      #5_000_000;
      $display("FAIL balance_frame_parser_unit");
      $finish;
   end

endmodule
